### rtl/scm_pkg.sv
// shared types, constants and rounding multiply for the sine/cosine unit
// no dependencies; used by every module of the block
package scm_pkg;

    localparam int AngleW   = 32;
    localparam int OutW     = 32;
    localparam int AccW     = 34;
    localparam int YW       = 32;
    localparam int ProdW    = 63;
    localparam int QW       = 8;
    localparam int RedW     = 49;
    localparam int YqW      = 45;
    localparam int PiW      = 44;
    localparam int NumCells = 5;

    localparam logic [127:0] E9 = 128'd1000000000;

    // constants scaled by 2^f and rounded to nearest, ties upward
    localparam logic [127:0] Inv2PiW = ((128'd159154943 << 32) + E9 / 2) / E9;
    localparam logic [127:0] TwoPiW  = ((128'd6283185307 << 40) + E9 / 2) / E9;
    localparam logic [127:0] PiHalfW = ((128'd1570796327 << 40) + E9 / 2) / E9;
    localparam logic [127:0] PiW_c   = ((128'd3141592654 << 40) + E9 / 2) / E9;

    localparam logic [127:0] C10W = ((128'd26051615 << 30) + 128'd50000000000000)
                                    / 128'd100000000000000;
    localparam logic [127:0] C8W  = ((128'd24760495 << 30) + 128'd500000000000)
                                    / 128'd1000000000000;
    localparam logic [127:0] C6W  = ((128'd13888378 << 30) + 128'd5000000000)
                                    / 128'd10000000000;
    localparam logic [127:0] C4W  = ((128'd41666638 << 30) + E9 / 2) / E9;
    localparam logic [127:0] C2W  = ((128'd5 << 30) + 128'd5) / 128'd10;
    localparam logic [127:0] S11W = ((128'd23889859 << 30) + 128'd500000000000000)
                                    / 128'd1000000000000000;
    localparam logic [127:0] S9W  = ((128'd27525562 << 30) + 128'd5000000000000)
                                    / 128'd10000000000000;
    localparam logic [127:0] S7W  = ((128'd19840874 << 30) + 128'd50000000000)
                                    / 128'd100000000000;
    localparam logic [127:0] S5W  = ((128'd83333310 << 30) + 128'd5000000000)
                                    / 128'd10000000000;
    localparam logic [127:0] S3W  = ((128'd16666667 << 30) + 128'd50000000)
                                    / 128'd100000000;

    localparam logic signed [30:0]      INV2PI  = 31'(Inv2PiW);
    localparam logic signed [PiW-1:0]   TWO_PI  = PiW'(TwoPiW);
    localparam logic signed [PiW-1:0]   PI_HALF = PiW'(PiHalfW);
    localparam logic signed [PiW-1:0]   PI      = PiW'(PiW_c);

    localparam logic signed [AccW-1:0] ONE_Q30 = AccW'(128'd1 << 30);
    localparam logic signed [AccW-1:0] C10 = -AccW'(C10W);
    localparam logic signed [AccW-1:0] C8  =  AccW'(C8W);
    localparam logic signed [AccW-1:0] C6  = -AccW'(C6W);
    localparam logic signed [AccW-1:0] C4  =  AccW'(C4W);
    localparam logic signed [AccW-1:0] C2  = -AccW'(C2W);
    localparam logic signed [AccW-1:0] S11 = -AccW'(S11W);
    localparam logic signed [AccW-1:0] S9  =  AccW'(S9W);
    localparam logic signed [AccW-1:0] S7  = -AccW'(S7W);
    localparam logic signed [AccW-1:0] S5  =  AccW'(S5W);
    localparam logic signed [AccW-1:0] S3  = -AccW'(S3W);

    localparam logic signed [AccW-1:0] COS_COEF [NumCells] = '{C8, C6, C4, C2, ONE_Q30};
    localparam logic signed [AccW-1:0] SIN_COEF [NumCells] = '{S9, S7, S5, S3, ONE_Q30};

    typedef struct packed {
        logic signed [AccW-1:0] pc;
        logic signed [AccW-1:0] ps;
        logic signed [AccW-1:0] y2;
        logic signed [YW-1:0]   y30;
        logic                   flip;
    } horner_t;

    // q30 product, rounded to nearest with ties upward
    function automatic logic signed [AccW-1:0] mul_q30(
        input logic signed [AccW-1:0] a,
        input logic signed [AccW-1:0] b
    );
        logic signed [2*AccW-1:0] p;
        logic signed [2*AccW-1:0] r;
        p = a * b;
        r = (p + (2*AccW)'(64'd1 << 29)) >>> 30;
        return r[AccW-1:0];
    endfunction

endpackage

### rtl/scm_front.sv
// angle reduction, fold and squaring: four pipeline stages
// depends on scm_pkg
module scm_front
    import scm_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [AngleW-1:0] in_angle,
    output logic                     out_valid,
    input  logic                     out_ready,
    output horner_t                  out_data
);

    logic [3:0] valid_reg;
    logic [3:0] rdy;

    logic signed [ProdW-1:0]  prod_reg;
    logic signed [AngleW-1:0] a1_reg;
    logic signed [YqW-1:0]    y_reg;
    logic signed [YW-1:0]     y30_reg;
    logic                     flip_reg;
    horner_t                  out_reg;

    logic signed [ProdW-1:0]  prod_next;
    logic signed [63:0]       q_full;
    logic signed [QW-1:0]     q;
    logic signed [RedW-1:0]   y_full;
    logic signed [YqW-1:0]    y_next;
    logic signed [YqW:0]      y_ext;
    logic signed [YqW:0]      y_abs;
    logic signed [YqW:0]      y_fold;
    logic signed [YqW:0]      y_rnd;
    logic                     flip_next;
    logic signed [YW-1:0]     y30_next;
    horner_t                  out_next;

    assign rdy[3] = !valid_reg[3] || out_ready;
    assign rdy[2] = !valid_reg[2] || rdy[3];
    assign rdy[1] = !valid_reg[1] || rdy[2];
    assign rdy[0] = !valid_reg[0] || rdy[1];
    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[3];
    assign out_data  = out_reg;

    always_comb begin
        prod_next = ProdW'(in_angle * INV2PI);

        // round quotient to the nearest turn count
        q_full = (64'(prod_reg) + (64'sd1 <<< 55)) >>> 56;
        q      = q_full[QW-1:0];
        y_full = (RedW'(a1_reg) <<< 16) - RedW'(q) * RedW'(TWO_PI);
        y_next = y_full[YqW-1:0];

        y_ext     = (YqW+1)'(y_reg);
        y_abs     = (y_reg < 0) ? -y_ext : y_ext;
        flip_next = y_abs > (YqW+1)'(PI_HALF);
        if (flip_next) begin
            y_fold = ((y_reg < 0) ? -(YqW+1)'(PI) : (YqW+1)'(PI)) - y_ext;
        end else begin
            y_fold = y_ext;
        end
        y_rnd    = (y_fold + (YqW+1)'(512)) >>> 10;
        y30_next = y_rnd[YW-1:0];

        out_next.pc   = C10;
        out_next.ps   = S11;
        out_next.y2   = mul_q30(AccW'(y30_reg), AccW'(y30_reg));
        out_next.y30  = y30_reg;
        out_next.flip = flip_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (rdy[0]) valid_reg[0] <= in_valid;
            if (rdy[1]) valid_reg[1] <= valid_reg[0];
            if (rdy[2]) valid_reg[2] <= valid_reg[1];
            if (rdy[3]) valid_reg[3] <= valid_reg[2];
        end
        if (rdy[0] && in_valid) begin
            prod_reg <= prod_next;
            a1_reg   <= in_angle;
        end
        if (rdy[1] && valid_reg[0]) begin
            y_reg <= y_next;
        end
        if (rdy[2] && valid_reg[1]) begin
            y30_reg  <= y30_next;
            flip_reg <= flip_next;
        end
        if (rdy[3] && valid_reg[2]) begin
            out_reg <= out_next;
        end
    end

endmodule

### rtl/scm_horner_cell.sv
// one horner step for the cosine and sine polynomials, registered
// depends on scm_pkg
module scm_horner_cell
    import scm_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic signed [AccW-1:0] cos_coef,
    input  logic signed [AccW-1:0] sin_coef,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  horner_t                in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output horner_t                out_data
);

    logic    valid_reg;
    horner_t data_reg;
    horner_t data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        data_next    = in_data;
        data_next.pc = mul_q30(in_data.pc, in_data.y2) + cos_coef;
        data_next.ps = mul_q30(in_data.ps, in_data.y2) + sin_coef;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

### rtl/sin_cos_minimax_unit.sv
// throughput: one angle per cycle while m_tready is held high;
// 4 reduction stages, 5 horner cells, 1 output stage
// each stage holds its item until the next one takes it, so bubbles close up under stall
// reset: aresetn synchronous, active low, clears all valid flags; no item is lost after
// depends on scm_pkg, scm_front, scm_horner_cell
module sin_cos_minimax_unit
    import scm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [AngleW-1:0]    s_tdata,   // [31:0] angle
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [2*OutW-1:0]    m_tdata    // [31:0] cos_value, [63:32] sin_value
);

    horner_t link_data  [NumCells+1];
    logic    link_valid [NumCells+1];
    logic    link_ready [NumCells+1];

    logic                   out_valid_reg;
    logic signed [OutW-1:0] cos_reg;
    logic signed [OutW-1:0] sin_reg;
    logic signed [AccW-1:0] cos_full;
    logic signed [AccW-1:0] sin_full;
    logic                   out_rdy;

    scm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_angle  (s_tdata),
        .out_valid (link_valid[0]),
        .out_ready (link_ready[0]),
        .out_data  (link_data[0])
    );

    for (genvar i = 0; i < NumCells; i++) begin : g_cell
        scm_horner_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cos_coef  (COS_COEF[i]),
            .sin_coef  (SIN_COEF[i]),
            .in_valid  (link_valid[i]),
            .in_ready  (link_ready[i]),
            .in_data   (link_data[i]),
            .out_valid (link_valid[i+1]),
            .out_ready (link_ready[i+1]),
            .out_data  (link_data[i+1])
        );
    end

    assign out_rdy              = !out_valid_reg || m_tready;
    assign link_ready[NumCells] = out_rdy;

    always_comb begin
        cos_full = link_data[NumCells].flip ? -link_data[NumCells].pc
                                            : link_data[NumCells].pc;
        sin_full = mul_q30(link_data[NumCells].ps, AccW'(link_data[NumCells].y30));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_rdy) begin
            out_valid_reg <= link_valid[NumCells];
        end
        if (out_rdy && link_valid[NumCells]) begin
            cos_reg <= cos_full[OutW-1:0];
            sin_reg <= sin_full[OutW-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {sin_reg, cos_reg};

endmodule
